/* rtl/ffa_pkg.sv */
// Shared types, sizes and helpers for the first-fit allocator.
// No dependencies; every other file in rtl/ but ffa_ram imports this package.
package ffa_pkg;

    localparam int POOL_UNITS  = 128;
    localparam int MAX_HANDLES = 128;
    localparam int QDEPTH      = 2;

    // unit numbers 0..POOL_UNITS, unit index 0..POOL_UNITS-1
    localparam int UNIT_W  = $clog2(POOL_UNITS + 1);
    localparam int UIDX_W  = (POOL_UNITS > 1) ? $clog2(POOL_UNITS) : 1;
    // handle counts 0..MAX_HANDLES, handle index 0..MAX_HANDLES-1
    localparam int HCNT_W  = $clog2(MAX_HANDLES + 1);
    localparam int HIDX_W  = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
    localparam int VAL_W   = (UNIT_W > HCNT_W) ? UNIT_W : HCNT_W;
    localparam int PS_W    = (UNIT_W > 8) ? UNIT_W : 8;

    localparam logic [7:0] POOL_SIZE_RESET = 8'd128;

    // request kinds
    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_ERASE  = 2'd1;
    localparam logic [1:0] FUNC_DEFRAG = 2'd2;

    // response status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] argument;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] handle;
    } rsp_t;

    // classified command passed from front to back
    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_ERASE   = 3'd1,
        OP_DEFRAG  = 3'd2,
        OP_NULL    = 3'd3,
        OP_ILLEGAL = 3'd4
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [VAL_W-1:0] val;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

    // bit i covers unit i+1
    function automatic logic [POOL_UNITS-1:0] range_mask(
        input logic [UNIT_W-1:0] lo,
        input logic [UNIT_W-1:0] hi
    );
        logic [POOL_UNITS-1:0] m;
        for (int i = 0; i < POOL_UNITS; i++) begin
            m[i] = (UNIT_W'(i + 1) >= lo) && (UNIT_W'(i + 1) <= hi);
        end
        return m;
    endfunction

    // lowest n units set
    function automatic logic [POOL_UNITS-1:0] low_mask(input logic [UNIT_W-1:0] n);
        logic [POOL_UNITS-1:0] m;
        for (int i = 0; i < POOL_UNITS; i++) begin
            m[i] = UNIT_W'(i) < n;
        end
        return m;
    endfunction

endpackage

/* rtl/first_fit_allocator_with_compaction.sv */
// First-fit allocator with compaction: top level.
// Depends on ffa_pkg, ffa_front, ffa_queue, ffa_back (and ffa_ram through ffa_back).
//
// Manages a pool of units 1..pool_size. A request transfer carries func
// (alloc, erase, defragment) and a signed argument. Alloc takes the lowest
// free run of the requested length and answers with a response transfer
// carrying status OK and the next sequential handle, or status NULL when no
// run fits, the size is out of range or all handles are spent. Erase frees a
// live handle silently; a bad handle answers ILLEGAL. Defragment slides all
// live blocks down toward unit 1 in address order and answers nothing. Func 3
// is taken and dropped. Requests are classified on entry and wait in a
// two-entry command queue, so the request side keeps flowing while the engine
// works or a response waits in its output register. The engine runs one
// command at a time: a command that answers at once (bad size or handle)
// answers from idle, an erase reads the block table and then clears its
// units, and an alloc runs the first-fit scan one unit per cycle until a run
// fits or the pool ends. Defragment builds the remap table over every unit,
// then reads and rewrites the table entry of each live handle and skips each
// dead one, and finally rebuilds the unit map. pool_size is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// and the block itself does not enforce this.
module first_fit_allocator_with_compaction (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    input  logic          req_valid,
    output logic          req_ready,
    input  ffa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ffa_pkg::rsp_t rsp
);
    import ffa_pkg::*;

    cmd_push_t push;      // classified command from the front end
    logic      q_full;
    logic      q_pop;
    logic      q_not_empty;
    cmd_t      q_head;

    // front end: checks that need no state, func 3 dropped here
    ffa_front u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_full    (q_full),
        .push      (push)
    );

    // decouples request acceptance from the engine
    ffa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // engine: unit map, handle table, scan and compaction, response register
    ffa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

/* rtl/ffa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ffa_front.sv */
// Request front end: takes request transfers and classifies them into commands.
// Depends on ffa_pkg.
module ffa_front (
    input  logic          req_valid,
    output logic          req_ready,
    input  ffa_pkg::req_t req,
    input  logic          q_full,
    output ffa_pkg::cmd_push_t push
);
    import ffa_pkg::*;

    logic alloc_bad;
    logic erase_bad;

    // argument checks that need no state
    assign alloc_bad = (req.argument < 16'sd1)
                    || (req.argument > $signed(16'(POOL_UNITS)));
    assign erase_bad = (req.argument < 16'sd1)
                    || (req.argument > $signed(16'(MAX_HANDLES)));

    assign req_ready = !q_full;

    always_comb
    begin
        push.valid   = req_valid && !q_full;
        push.cmd.op  = OP_DEFRAG;
        push.cmd.val = VAL_W'(req.argument[VAL_W-1:0]);
        unique case (req.func)
            FUNC_ALLOC:  push.cmd.op = alloc_bad ? OP_NULL : OP_ALLOC;
            FUNC_ERASE:  push.cmd.op = erase_bad ? OP_ILLEGAL : OP_ERASE;
            FUNC_DEFRAG: push.cmd.op = OP_DEFRAG;
            default:     push.valid  = 1'b0;   // unused kind: taken and dropped
        endcase
    end

endmodule

/* rtl/ffa_queue.sv */
// Short command queue between the front end and the allocator engine.
// Depends on ffa_pkg.
module ffa_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  ffa_pkg::cmd_push_t push,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output ffa_pkg::cmd_t      head
);
    import ffa_pkg::*;

    localparam int QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W = $clog2(QDEPTH + 1);

    cmd_t            entry_reg [QDEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == QC_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

/* rtl/ffa_back.sv */
// Allocator engine: unit map, handle table, first-fit scan, erase, compaction,
// response register and the pool_size register. Depends on ffa_pkg, ffa_ram.
module ffa_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    input  logic          cmd_valid,
    input  ffa_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ffa_pkg::rsp_t rsp
);
    import ffa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ASCAN  = 7'b0000010,
        S_ECLR   = 7'b0000100,
        S_DCOUNT = 7'b0001000,
        S_DHSEL  = 7'b0010000,
        S_DHRD   = 7'b0100000,
        S_DHWR   = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [POOL_UNITS-1:0]   used_reg, used_next;
    logic [MAX_HANDLES-1:0]  live_reg, live_next;
    logic [HCNT_W-1:0]       hcnt_reg, hcnt_next;
    logic [HCNT_W-1:0]       hidx_reg, hidx_next;
    logic [UNIT_W-1:0]       ucnt_reg, ucnt_next;
    logic [UNIT_W-1:0]       run_reg, run_next;
    logic [UNIT_W-1:0]       want_reg, want_next;
    logic [UNIT_W-1:0]       fill_reg, fill_next;
    logic [7:0]              pool_size_reg;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    // block table: {start, end} per handle; compaction remap: new unit per unit
    logic                    blk_we, blk_re;
    logic [HIDX_W-1:0]       blk_waddr, blk_raddr;
    logic [2*UNIT_W-1:0]     blk_wdata, blk_rdata;
    logic                    np_we, np_re;
    logic [UIDX_W-1:0]       np_waddr, np_raddr;
    logic [UNIT_W-1:0]       np_wdata, np_rdata;

    logic [UNIT_W-1:0]       psize;
    logic                    slot_free;
    logic [UNIT_W-1:0]       cmd_want;
    logic [HCNT_W-1:0]       cmd_handle;
    logic [UNIT_W-1:0]       run_inc;
    logic [UNIT_W-1:0]       blk_start, blk_end;

    ffa_ram #(.WIDTH(2 * UNIT_W), .DEPTH(MAX_HANDLES)) u_blk_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .re    (blk_re),
        .raddr (blk_raddr),
        .rdata (blk_rdata)
    );

    ffa_ram #(.WIDTH(UNIT_W), .DEPTH(POOL_UNITS)) u_npos_ram (
        .clk   (clk),
        .we    (np_we),
        .waddr (np_waddr),
        .wdata (np_wdata),
        .re    (np_re),
        .raddr (np_raddr),
        .rdata (np_rdata)
    );

    assign psize = (PS_W'(pool_size_reg) > PS_W'(POOL_UNITS))
                 ? UNIT_W'(POOL_UNITS) : UNIT_W'(pool_size_reg);
    assign slot_free  = !rsp_valid_reg || rsp_ready;
    assign cmd_want   = cmd.val[UNIT_W-1:0];
    assign cmd_handle = cmd.val[HCNT_W-1:0];
    assign run_inc    = used_reg[ucnt_reg[UIDX_W-1:0]] ? '0 : run_reg + 1'b1;
    assign blk_start  = blk_rdata[2*UNIT_W-1:UNIT_W];
    assign blk_end    = blk_rdata[UNIT_W-1:0];
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        live_next      = live_reg;
        hcnt_next      = hcnt_reg;
        hidx_next      = hidx_reg;
        ucnt_next      = ucnt_reg;
        run_next       = run_reg;
        want_next      = want_reg;
        fill_next      = fill_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd_pop        = 1'b0;
        blk_we         = 1'b0;
        blk_waddr      = hidx_reg[HIDX_W-1:0];
        blk_wdata      = '0;
        blk_re         = 1'b0;
        blk_raddr      = hidx_reg[HIDX_W-1:0];
        np_we          = 1'b0;
        np_waddr       = ucnt_reg[UIDX_W-1:0];
        np_wdata       = '0;
        np_re          = 1'b0;
        np_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_NULL:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '{status: ST_NULL, handle: 8'd0};
                        end
                        OP_ILLEGAL:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '{status: ST_ILLEGAL, handle: 8'd0};
                        end
                        OP_ALLOC:
                        begin
                            if (cmd_want > psize || hcnt_reg >= HCNT_W'(MAX_HANDLES))
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = '{status: ST_NULL, handle: 8'd0};
                            end
                            else
                            begin
                                want_next  = cmd_want;
                                ucnt_next  = '0;
                                run_next   = '0;
                                state_next = S_ASCAN;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (cmd_handle > hcnt_reg
                                || !live_reg[HIDX_W'(cmd_handle - 1'b1)])
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = '{status: ST_ILLEGAL, handle: 8'd0};
                            end
                            else
                            begin
                                hidx_next  = cmd_handle - 1'b1;
                                blk_re     = 1'b1;
                                blk_raddr  = HIDX_W'(cmd_handle - 1'b1);
                                state_next = S_ECLR;
                            end
                        end
                        OP_DEFRAG:
                        begin
                            ucnt_next  = '0;
                            fill_next  = '0;
                            state_next = S_DCOUNT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // first fit: one unit per cycle, run length of free units
            S_ASCAN:
            begin
                if (ucnt_reg >= psize)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: ST_NULL, handle: 8'd0};
                    state_next     = S_IDLE;
                end
                else if (run_inc == want_reg)
                begin
                    blk_we    = 1'b1;
                    blk_waddr = hcnt_reg[HIDX_W-1:0];
                    blk_wdata = {UNIT_W'(ucnt_reg - want_reg + 2'd2), UNIT_W'(ucnt_reg + 1'b1)};
                    used_next = used_reg | range_mask(UNIT_W'(ucnt_reg - want_reg + 2'd2),
                                                      UNIT_W'(ucnt_reg + 1'b1));
                    live_next[hcnt_reg[HIDX_W-1:0]] = 1'b1;
                    hcnt_next      = hcnt_reg + 1'b1;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: ST_OK, handle: 8'(hcnt_reg + 1'b1)};
                    state_next     = S_IDLE;
                end
                else
                begin
                    run_next  = run_inc;
                    ucnt_next = ucnt_reg + 1'b1;
                end
            end

            S_ECLR:
            begin
                used_next = used_reg & ~range_mask(blk_start, blk_end);
                live_next[hidx_reg[HIDX_W-1:0]] = 1'b0;
                state_next = S_IDLE;
            end

            // compaction pass 1: new position of every unit = used units up to it
            S_DCOUNT:
            begin
                np_we     = 1'b1;
                np_waddr  = ucnt_reg[UIDX_W-1:0];
                np_wdata  = fill_reg + UNIT_W'(used_reg[ucnt_reg[UIDX_W-1:0]]);
                fill_next = np_wdata;
                ucnt_next = ucnt_reg + 1'b1;
                if (ucnt_reg == UNIT_W'(POOL_UNITS - 1))
                begin
                    hidx_next  = '0;
                    state_next = S_DHSEL;
                end
            end

            // compaction pass 2: remap each live block
            S_DHSEL:
            begin
                if (hidx_reg >= hcnt_reg)
                begin
                    used_next  = low_mask(fill_reg);
                    state_next = S_IDLE;
                end
                else if (live_reg[hidx_reg[HIDX_W-1:0]])
                begin
                    blk_re     = 1'b1;
                    state_next = S_DHRD;
                end
                else
                begin
                    hidx_next = hidx_reg + 1'b1;
                end
            end

            S_DHRD:
            begin
                np_re      = 1'b1;
                np_raddr   = UIDX_W'(blk_start - 1'b1);
                state_next = S_DHWR;
            end

            S_DHWR:
            begin
                blk_we     = 1'b1;
                blk_wdata  = {np_rdata, UNIT_W'(np_rdata + (blk_end - blk_start))};
                hidx_next  = hidx_reg + 1'b1;
                state_next = S_DHSEL;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            live_reg      <= '0;
            hcnt_reg      <= '0;
            pool_size_reg <= POOL_SIZE_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            live_reg      <= live_next;
            hcnt_reg      <= hcnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                pool_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hidx_reg <= hidx_next;
        ucnt_reg <= ucnt_next;
        run_reg  <= run_next;
        want_reg <= want_next;
        fill_reg <= fill_next;
        rsp_reg  <= rsp_next;
    end

endmodule

/* tb/tb.sv */
// Self-checking testbench for first_fit_allocator_with_compaction.
// Depends on ffa_pkg and the allocator RTL. Runs a directed opener, then
// random traffic over several pool sizes, checked against a built-in allocator.
module tb;
    import ffa_pkg::*;

    // Request kind with no meaning; the block must drop it silently.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // A defragment runs a full remap pass and then walks every handle, and up to
    // two more commands can sit in the command queue behind the running one.
    // Silent commands give no completion signal, so before a pool_size write
    // (and at the very end) we wait out DRAIN_CYCLES after the last result.
    localparam int DRAIN_CYCLES = 2000;
    // Cycles with no transfer on either channel and no register write.
    localparam int STALL_LIMIT  = 10000;

    typedef enum logic [1:0] {
        STEP_REQ,   // send one request
        STEP_CFG,   // write pool_size
        STEP_WAIT   // hold off until no response is owed, then idle a while
    } step_kind_t;

    typedef struct {
        step_kind_t kind;
        req_t       req;
        logic [7:0] value;
        int         hold;
    } step_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_t       req       = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_t       rsp;

    first_fit_allocator_with_compaction uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator shadow: unit map, block table, handle counter, pool size.
    // Updated at the edge where a request transfer is accepted.
    // ------------------------------------------------------------------
    bit unit_used [1:POOL_UNITS];
    int blk_lo    [1:MAX_HANDLES];
    int blk_hi    [1:MAX_HANDLES];
    bit blk_live  [1:MAX_HANDLES];
    int issued    = 0;
    int pool_lim  = int'(POOL_SIZE_RESET);

    rsp_t rsp_expected [$];   // responses owed by the block, oldest first
    step_t script [$];        // stimulus still to be driven

    int fail_count   = 0;
    int quiet_cycles = 0;

    // Returns 1 when the request produces a response, placed in o.
    function automatic bit apply_request(input req_t r, output rsp_t o);
        int arg;
        int psize;
        int run;
        int u;
        int h;
        int k;
        int gap;
        bit placed;
        bit was_used [1:POOL_UNITS];
        o.status = ST_NULL;
        o.handle = 8'd0;
        arg = $signed(r.argument);
        case (r.func)
            FUNC_ALLOC:
            begin
                // register values above the array size act as the full pool
                psize = (pool_lim > POOL_UNITS) ? POOL_UNITS : pool_lim;
                if (arg >= 1 && arg <= psize && issued < MAX_HANDLES)
                begin
                    run = 0;
                    placed = 1'b0;
                    for (u = 1; u <= psize && !placed; u++)
                    begin
                        run = unit_used[u] ? 0 : run + 1;
                        if (run == arg)
                        begin
                            issued++;
                            h = issued;
                            blk_lo[h] = u - arg + 1;
                            blk_hi[h] = u;
                            blk_live[h] = 1'b1;
                            for (k = blk_lo[h]; k <= u; k++)
                                unit_used[k] = 1'b1;
                            o.status = ST_OK;
                            o.handle = 8'(h);
                            placed = 1'b1;
                        end
                    end
                end
                return 1'b1;
            end
            FUNC_ERASE:
            begin
                if (arg < 1 || arg > issued || arg > MAX_HANDLES || !blk_live[arg])
                begin
                    o.status = ST_ILLEGAL;
                    return 1'b1;
                end
                for (k = blk_lo[arg]; k <= blk_hi[arg] && k <= POOL_UNITS; k++)
                    if (k >= 1)
                        unit_used[k] = 1'b0;
                blk_live[arg] = 1'b0;
                return 1'b0;
            end
            FUNC_DEFRAG:
            begin
                // every shift is measured against the map as it was before compaction
                for (u = 1; u <= POOL_UNITS; u++)
                    was_used[u] = unit_used[u];
                for (h = 1; h <= issued && h <= MAX_HANDLES; h++)
                begin
                    if (blk_live[h])
                    begin
                        gap = 0;
                        for (u = 1; u <= blk_lo[h] && u <= POOL_UNITS; u++)
                            if (!was_used[u])
                                gap++;
                        blk_lo[h] -= gap;
                        blk_hi[h] -= gap;
                    end
                end
                for (u = 1; u <= POOL_UNITS; u++)
                    unit_used[u] = 1'b0;
                for (h = 1; h <= issued && h <= MAX_HANDLES; h++)
                    if (blk_live[h])
                        for (k = blk_lo[h]; k <= blk_hi[h] && k <= POOL_UNITS; k++)
                            if (k >= 1)
                                unit_used[k] = 1'b1;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    int gen_allocs = 0;   // alloc requests queued so far; bounds erase handles

    task automatic push_req(input logic [1:0] f, input int arg);
        step_t s;
        s.kind = STEP_REQ;
        s.req.func = f;
        s.req.argument = 16'(arg);
        s.value = 8'd0;
        s.hold = 0;
        if (f == FUNC_ALLOC)
            gen_allocs++;
        script.push_back(s);
    endtask

    task automatic push_wait(input int hold);
        step_t s;
        s.kind = STEP_WAIT;
        s.req = '0;
        s.value = 8'd0;
        s.hold = hold;
        script.push_back(s);
    endtask

    // pool_size is only written with the block idle
    task automatic push_cfg(input int v);
        step_t s;
        push_wait(DRAIN_CYCLES);
        s.kind = STEP_CFG;
        s.req = '0;
        s.value = 8'(v);
        s.hold = 0;
        script.push_back(s);
    endtask

    function automatic int pick_size(input int lim);
        int r;
        int top;
        r = $urandom_range(0, 19);
        top = (lim < 1) ? 1 : lim;
        if (r == 0)
            return ($urandom_range(0, 1) == 0) ? 0 : -int'($urandom_range(1, 32768));
        if (r == 1)
            return lim;
        if (r == 2)
            return lim + 1;
        if (r <= 5)
            return int'($urandom_range(1, top));
        return int'($urandom_range(1, (top < 12) ? top : 12));
    endfunction

    function automatic int pick_handle();
        int r;
        int hi;
        r = $urandom_range(0, 19);
        hi = (gen_allocs < 1) ? 1 : gen_allocs;
        if (r == 0)
            return ($urandom_range(0, 1) == 0) ? 0 : -int'($urandom_range(1, 32768));
        if (r == 1)
            return int'($urandom_range(1, 32767));
        // mostly recent handles, which are the ones most likely still live
        if (r < 12)
            return int'($urandom_range((hi > 8) ? hi - 8 : 1, hi));
        return int'($urandom_range(1, hi));
    endfunction

    // One pool_size setting followed by n random requests. Most traffic is
    // alloc/erase churn on plausible handles; a slice is raw noise.
    task automatic random_phase(input int pool, input int n);
        int made;
        int sel;
        int lim;
        push_cfg(pool);
        lim = (pool > POOL_UNITS) ? POOL_UNITS : pool;
        made = 0;
        while (made < n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 42)
                push_req(FUNC_ALLOC, pick_size(lim));
            else if (sel < 74)
                push_req(FUNC_ERASE, pick_handle());
            else if (sel < 85)
                push_req(FUNC_DEFRAG, int'($urandom_range(0, 65535)));
            else if (sel < 88)
            begin
                // sender holds until every owed response is back
                push_wait(0);
                made--;
            end
            else
                push_req(2'($urandom_range(0, 3)), int'($urandom_range(0, 65535)));
            made++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts with random gaps, fed from the script.
    // ------------------------------------------------------------------
    int burst_left = 4;
    int gap_left   = 0;
    int wait_cnt   = 0;

    always @(posedge clk)
    begin : driver
        step_t      head;
        rsp_t       owed;
        logic       nxt_valid;
        req_t       nxt_req;
        logic       nxt_we;
        logic [7:0] nxt_wdata;
        nxt_valid = req_valid;
        nxt_req   = req;
        nxt_we    = 1'b0;
        nxt_wdata = cfg_wdata;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                if (apply_request(req, owed))
                    rsp_expected.push_back(owed);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (script.size() != 0)
                begin
                    head = script[0];
                    case (head.kind)
                        STEP_REQ:
                        begin
                            void'(script.pop_front());
                            nxt_valid = 1'b1;
                            nxt_req = head.req;
                            burst_left--;
                            if (burst_left <= 0)
                            begin
                                gap_left = ($urandom_range(0, 3) == 0) ? 0
                                                                       : $urandom_range(1, 24);
                                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                                         : $urandom_range(1, 8);
                            end
                        end
                        STEP_CFG:
                        begin
                            void'(script.pop_front());
                            nxt_we = 1'b1;
                            nxt_wdata = head.value;
                            pool_lim = int'(head.value);
                        end
                        STEP_WAIT:
                        begin
                            if (rsp_expected.size() != 0)
                                wait_cnt = 0;
                            else if (wait_cnt >= head.hold)
                            begin
                                void'(script.pop_front());
                                wait_cnt = 0;
                            end
                            else
                                wait_cnt++;
                        end
                        default:
                            void'(script.pop_front());
                    endcase
                end
            end
        end
        req_valid <= nxt_valid;
        req       <= nxt_req;
        cfg_we    <= nxt_we;
        cfg_wdata <= nxt_wdata;
    end

    // ------------------------------------------------------------------
    // Response side: ready follows a mode picked at random whenever its hold
    // count runs out (always ready, short stalls, long stalls).
    // ------------------------------------------------------------------
    int ready_mode = 0;
    int mode_left  = 100;
    int stall_left = 0;

    always @(posedge clk)
    begin : receiver
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 300);
        end
        else
            mode_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            nxt_ready = 1'b0;
        end
        else if (ready_mode == 1 && $urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            nxt_ready = 1'b0;
        end
        else if (ready_mode == 2 && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(5, 30);
            nxt_ready = 1'b0;
        end
        rsp_ready <= nxt_ready;
    end

    // Compare each response transfer with the oldest owed response.
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (rsp_expected.size() == 0)
            begin
                $error("response with none owed: status %0d handle %0d",
                       rsp.status, rsp.handle);
                fail_count++;
            end
            else
            begin
                want = rsp_expected.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.handle !== want.handle)
                begin
                    $error("handle mismatch: expected %0d, actual %0d", want.handle, rsp.handle);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which nothing moves.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Scenario and end of run
    // ------------------------------------------------------------------
    initial
    begin : scenario
        bit timed_out;

        // Directed opener at the reset pool size of 128.
        push_req(FUNC_ALLOC, 0);          // size below one
        push_req(FUNC_ALLOC, -1);
        push_req(FUNC_ALLOC, -32768);
        push_req(FUNC_ALLOC, 32767);      // size above pool
        push_req(FUNC_ALLOC, 129);
        push_req(FUNC_ALLOC, 128);        // whole pool in one block
        push_req(FUNC_ALLOC, 1);          // pool full
        push_req(FUNC_ERASE, 0);          // zero handle
        push_req(FUNC_ERASE, -32768);     // negative handle
        push_req(FUNC_ERASE, 2);          // never issued
        push_req(FUNC_ERASE, 32767);
        push_req(FUNC_ERASE, 1);          // good erase, silent
        push_req(FUNC_ERASE, 1);          // already erased
        push_req(FUNC_ALLOC, 10);
        push_req(FUNC_ALLOC, 20);
        push_req(FUNC_ALLOC, 5);
        push_req(FUNC_ERASE, 3);          // hole in the middle
        push_req(FUNC_DEFRAG, 16'hFFFF);  // slides the last block down
        push_req(FUNC_ALLOC, 113);        // exactly fits what compaction freed
        push_req(FUNC_SPARE, 16'hFFFF);   // dropped
        push_req(FUNC_SPARE, 0);
        push_req(FUNC_ERASE, 2);
        push_req(FUNC_DEFRAG, 0);
        push_req(FUNC_ALLOC, 1);

        // Random phases across pool sizes, extremes included. Handles run out
        // part way through, after which allocs saturate to null.
        random_phase(0, 10);
        random_phase(128, 120);
        random_phase(1, 25);
        random_phase(255, 60);
        random_phase(64, 80);
        random_phase($urandom_range(2, 127), 80);
        random_phase(128, 100);
        random_phase($urandom_range(129, 254), 60);

        // Reset: held low, then released at an edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at falling edges so the checks see settled values.
        timed_out = 1'b0;
        while (!(script.size() == 0 && !req_valid && rsp_expected.size() == 0) && !timed_out)
        begin
            @(negedge clk);
            timed_out = (quiet_cycles >= STALL_LIMIT);
        end
        // Give silent commands time to finish, catching any stray response.
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(negedge clk);

        if (timed_out || rsp_expected.size() != 0)
            $display("simulation failed");
        else if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
